// ----- hw/rtl/fbsr_pkg.sv -----
// shared constants, item layout and types of the frame buffer slot rotation block
package fbsr_pkg;

  localparam int BUFFER_COUNT_DEF = 4;

  localparam int ADDR_W = 32;
  localparam int RES_W  = 12;
  localparam int LEN_W  = 28;
  localparam int EXP_W  = 2 * RES_W + 1;

  localparam logic [ADDR_W-1:0] REGION_BASE = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] BUFFER_SIZE = 32'd8294400;  // 1920 x 1080 x 4 bytes

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_HEIGHT = 1'b1;

  // input item layout
  localparam int IN_PEND0 = 0;
  localparam int IN_ADDR0 = 1;
  localparam int IN_PEND1 = 33;
  localparam int IN_ADDR1 = 34;
  localparam int IN_W     = 72;

  // result item layout
  localparam int OUT_RELOAD0  = 0;
  localparam int OUT_ADDR0    = 1;
  localparam int OUT_RELOAD1  = 33;
  localparam int OUT_ADDR1    = 34;
  localparam int OUT_SHOWN    = 66;
  localparam int OUT_CHANGED  = 68;
  localparam int OUT_BAD0     = 69;
  localparam int OUT_BAD1     = 70;
  localparam int OUT_STRAY0   = 71;
  localparam int OUT_STRAY1   = 72;
  localparam int OUT_USED     = 73;
  localparam int OUT_W        = 80;

  typedef struct packed {
    logic reload;
    logic good;
    logic bad_length;
    logic stray;
  } slot_flags_t;

endpackage

// ----- hw/rtl/frame_buffer_slot_rotation.sv -----
// top level: frame buffer slot rotation for a two-slot capture dma
//
// s_* carries one capture-done item: pending flag and end address of each slot.
// m_* carries one result item per input item: reload flags and new buffer
// start of each slot, the shown buffer index, a changed flag, and bad length
// and stray flags per slot.
// cfg_* writes active_width (index 0) or active_height (index 1); cfg_ready
// is always high and a write takes effect for the next item.
// m_tvalid rises in the cycle after acceptance. One item is taken each
// cycle unless the receiver stalls: slot checks, ring advance and shown
// update all settle in one logic pass from the input handshake into the result register.
// The expected length uses one 12 x 12 multiplier in that pass.
// While the receiver stalls, the result register holds and s_tready drops
// only when a result is waiting and m_tready is low.
// Synchronous reset empties the result register, zeroes both resolution
// registers and sets slot 0 to buffer 0, slot 1 to buffer 1, the next free
// buffer to 2 and the shown buffer to 3.
module frame_buffer_slot_rotation #(
  parameter int BUFFER_COUNT = fbsr_pkg::BUFFER_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // slot0_pending, slot0_end_address, slot1_pending, slot1_end_address
  input  logic [fbsr_pkg::IN_W-1:0]        s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // slot0_reload, slot0_address, slot1_reload, slot1_address, shown_buffer,
  // shown_changed, slot0_bad_length, slot1_bad_length, slot0_stray, slot1_stray
  output logic [fbsr_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbsr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbsr_pkg::RES_W-1:0]       cfg_data
);
  import fbsr_pkg::*;

  localparam int IDX_W = (BUFFER_COUNT > 4) ? $clog2(BUFFER_COUNT) : 2;

  logic [RES_W-1:0]  active_width;
  logic [RES_W-1:0]  active_height;
  logic [IDX_W-1:0]  slot0_buffer;
  logic [IDX_W-1:0]  slot1_buffer;
  logic [IDX_W-1:0]  next_buffer;
  logic [IDX_W-1:0]  shown_index;
  logic [IDX_W-1:0]  shown_index_next;
  logic [EXP_W-1:0]  expected;
  logic [2*RES_W-1:0] area;

  logic [IDX_W-1:0]  s0_new_buffer, s0_new_next;
  logic [IDX_W-1:0]  s1_new_buffer, s1_new_next;
  logic [ADDR_W-1:0] s0_address, s1_address;
  slot_flags_t       s0_flags, s1_flags;
  logic [OUT_W-1:0]  result_next;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  assign area     = (2*RES_W)'(active_width) * (2*RES_W)'(active_height);
  assign expected = {area, 1'b0};

  fbsr_slot #(.BUFFER_COUNT(BUFFER_COUNT), .IDX_W(IDX_W)) u_slot0 (
    .pending     (s_tdata[IN_PEND0]),
    .end_address (s_tdata[IN_ADDR0 +: ADDR_W]),
    .expected    (expected),
    .cur_buffer  (slot0_buffer),
    .next_buffer (next_buffer),
    .new_buffer  (s0_new_buffer),
    .new_next    (s0_new_next),
    .address     (s0_address),
    .flags       (s0_flags)
  );

  // slot 1 sees the ring after slot 0 has taken its share
  fbsr_slot #(.BUFFER_COUNT(BUFFER_COUNT), .IDX_W(IDX_W)) u_slot1 (
    .pending     (s_tdata[IN_PEND1]),
    .end_address (s_tdata[IN_ADDR1 +: ADDR_W]),
    .expected    (expected),
    .cur_buffer  (slot1_buffer),
    .next_buffer (s0_new_next),
    .new_buffer  (s1_new_buffer),
    .new_next    (s1_new_next),
    .address     (s1_address),
    .flags       (s1_flags)
  );

  always_comb begin
    priority if (s1_flags.good) begin
      shown_index_next = slot1_buffer;
    end else if (s0_flags.good) begin
      shown_index_next = slot0_buffer;
    end else begin
      shown_index_next = shown_index;
    end

    result_next = '0;
    result_next[OUT_RELOAD0]          = s0_flags.reload;
    result_next[OUT_ADDR0 +: ADDR_W]  = s0_address;
    result_next[OUT_RELOAD1]          = s1_flags.reload;
    result_next[OUT_ADDR1 +: ADDR_W]  = s1_address;
    result_next[OUT_SHOWN +: 2]       = shown_index_next[1:0];
    result_next[OUT_CHANGED]          = s0_flags.good || s1_flags.good;
    result_next[OUT_BAD0]             = s0_flags.bad_length;
    result_next[OUT_BAD1]             = s1_flags.bad_length;
    result_next[OUT_STRAY0]           = s0_flags.stray;
    result_next[OUT_STRAY1]           = s1_flags.stray;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= '0;
      active_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE_WIDTH:  active_width  <= cfg_data;
        CFG_ACTIVE_HEIGHT: active_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_buffer <= IDX_W'(0);
      slot1_buffer <= IDX_W'(1);
      next_buffer  <= IDX_W'(2);
      shown_index  <= IDX_W'(3);
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        slot0_buffer <= s0_new_buffer;
        slot1_buffer <= s1_new_buffer;
        next_buffer  <= s1_new_next;
        shown_index  <= shown_index_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_next;
    end
  end

endmodule

// ----- hw/rtl/fbsr_slot.sv -----
// one dma slot: region check, frame length check and ring advance
module fbsr_slot #(
  parameter int BUFFER_COUNT = fbsr_pkg::BUFFER_COUNT_DEF,
  parameter int IDX_W        = 2
) (
  input  logic                        pending,
  input  logic [fbsr_pkg::ADDR_W-1:0] end_address,
  input  logic [fbsr_pkg::EXP_W-1:0]  expected,
  input  logic [IDX_W-1:0]            cur_buffer,
  input  logic [IDX_W-1:0]            next_buffer,
  output logic [IDX_W-1:0]            new_buffer,
  output logic [IDX_W-1:0]            new_next,
  output logic [fbsr_pkg::ADDR_W-1:0] address,
  output fbsr_pkg::slot_flags_t       flags
);
  import fbsr_pkg::*;

  localparam logic [IDX_W:0] COUNT = (IDX_W+1)'(BUFFER_COUNT);
  localparam logic [ADDR_W-1:0] REGION_TOP = REGION_BASE + BUFFER_SIZE * ADDR_W'(BUFFER_COUNT);

  logic [IDX_W:0]      cur_ext;
  logic [IDX_W:0]      new_ext;
  logic [IDX_W:0]      next_inc;
  logic [IDX_W-1:0]    cur_slot;
  logic [IDX_W-1:0]    new_slot;
  logic [ADDR_W-1:0]   cur_start;
  logic [ADDR_W-1:0]   new_start;
  logic [ADDR_W-1:0]   diff;
  logic                good;

  // indices never reach twice the ring size, so one subtract folds them
  always_comb begin
    cur_ext  = {1'b0, cur_buffer};
    cur_slot = (cur_ext >= COUNT) ? IDX_W'(cur_ext - COUNT) : cur_buffer;
    cur_start = REGION_BASE + ADDR_W'(cur_slot) * BUFFER_SIZE;
    diff      = end_address - cur_start;
    good      = pending && (diff[LEN_W-1:0] == LEN_W'(expected));

    next_inc = {1'b0, next_buffer} + (IDX_W+1)'(1);
    new_buffer = good ? next_buffer : cur_buffer;
    new_next   = good ? ((next_inc >= COUNT) ? '0 : IDX_W'(next_inc)) : next_buffer;

    new_ext   = {1'b0, new_buffer};
    new_slot  = (new_ext >= COUNT) ? IDX_W'(new_ext - COUNT) : new_buffer;
    new_start = REGION_BASE + ADDR_W'(new_slot) * BUFFER_SIZE;
    address   = pending ? new_start : '0;

    flags.reload     = pending;
    flags.good       = good;
    flags.bad_length = pending && !good;
    flags.stray      = pending && ((end_address < REGION_BASE) || (end_address > REGION_TOP));
  end

endmodule

// ----- hw/rtl/fbsr_checker.sv -----
// port-level checks of the frame buffer slot rotation block and their bind
module fbsr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [fbsr_pkg::OUT_W-1:0]       m_tdata
);
  import fbsr_pkg::*;

  // a waiting result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // an accepted item always yields a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // an idle slot 0 reports no bad length, no stray and no address
  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OUT_RELOAD0] |->
      m_tdata[OUT_ADDR0 +: ADDR_W] == '0 && !m_tdata[OUT_BAD0] && !m_tdata[OUT_STRAY0])
    else $error("idle slot 0 carries flags or address");

  // a change of shown buffer needs a slot with a good frame
  a_changed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_CHANGED] |->
      (m_tdata[OUT_RELOAD0] && !m_tdata[OUT_BAD0]) ||
      (m_tdata[OUT_RELOAD1] && !m_tdata[OUT_BAD1]))
    else $error("shown buffer changed without a good frame");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind frame_buffer_slot_rotation fbsr_checker u_fbsr_checker (.*);
